>>> hdl/gvrw_pkg.sv
// shared types and constants for the grid voxel ray walker
`default_nettype none
package gvrw_pkg;
	localparam int DATA_W = 32;
	localparam int FRAC_BITS = 16;
	localparam int MAX_CELLS = 16;
	localparam int POS_W = $clog2(MAX_CELLS);
	localparam int ID_W = 12;
	localparam int CELLS_W = 5;
	localparam int SIZE_W = 31;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_AX = 3;
	localparam int AX_W = 2;
	localparam int MUL_A_W = 38;
	localparam int PROD_W = 2 * DATA_W;
	localparam int MAG_W = PROD_W + 8;

	localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 3'd5;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_STEP = 1'b1
	} op_t;

	typedef struct packed {
		op_t op;
		logic [NUM_AX-1:0][DATA_W-1:0] origin;
		logic [NUM_AX-1:0][DATA_W-1:0] dir;
		logic [NUM_AX-1:0][DATA_W-1:0] inv_dir;
		logic [DATA_W-1:0] t_start;
	} item_t;

	typedef struct packed {
		logic [NUM_AX-1:0][CELLS_W-1:0] cells;
		logic [NUM_AX-1:0][SIZE_W-1:0] size;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AXIS,
		ST_MLO,
		ST_MHI,
		ST_MFIN,
		ST_USE,
		ST_DIV,
		ST_ADV,
		ST_ID,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		MK_T,
		MK_B,
		MK_D
	} mul_kind_t;
endpackage
`default_nettype wire

>>> hdl/gvrw_front.sv
// front end: accepts items, classifies the command and queues them
`default_nettype none
module gvrw_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic cmd,
	input  wire logic [gvrw_pkg::DATA_W-1:0] origin_x,
	input  wire logic [gvrw_pkg::DATA_W-1:0] origin_y,
	input  wire logic [gvrw_pkg::DATA_W-1:0] origin_z,
	input  wire logic [gvrw_pkg::DATA_W-1:0] dir_x,
	input  wire logic [gvrw_pkg::DATA_W-1:0] dir_y,
	input  wire logic [gvrw_pkg::DATA_W-1:0] dir_z,
	input  wire logic [gvrw_pkg::DATA_W-1:0] inv_dir_x,
	input  wire logic [gvrw_pkg::DATA_W-1:0] inv_dir_y,
	input  wire logic [gvrw_pkg::DATA_W-1:0] inv_dir_z,
	input  wire logic [gvrw_pkg::DATA_W-1:0] t_start,
	output logic q_valid,
	output gvrw_pkg::item_t q_item,
	input  wire logic q_pop
);
	import gvrw_pkg::*;

	item_t fifo_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	item_t item_c;
	logic push;

	always_comb begin
		item_c.op = cmd ? OP_STEP : OP_LOAD;
		item_c.origin = {origin_z, origin_y, origin_x};
		item_c.dir = {dir_z, dir_y, dir_x};
		item_c.inv_dir = {inv_dir_z, inv_dir_y, inv_dir_x};
		item_c.t_start = t_start;
	end

	assign in_stall = (count_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign q_valid = (count_q != 2'd0);
	assign q_item = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (q_pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !q_pop)
				count_q <= count_q + 2'd1;
			else if (!push && q_pop)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= item_c;
	end
endmodule
`default_nettype wire

>>> hdl/gvrw_back.sv
// back end: ray setup and voxel stepping sequencer with a shared multiplier
`default_nettype none
module gvrw_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire gvrw_pkg::cfg_t cfg,
	input  wire logic q_valid,
	input  wire gvrw_pkg::item_t q_item,
	output logic q_pop,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [gvrw_pkg::ID_W-1:0] voxel_id,
	output logic [gvrw_pkg::POS_W-1:0] voxel_x,
	output logic [gvrw_pkg::POS_W-1:0] voxel_y,
	output logic [gvrw_pkg::POS_W-1:0] voxel_z,
	output logic [gvrw_pkg::DATA_W-1:0] t_exit,
	output logic left_grid
);
	import gvrw_pkg::*;

	state_t state_q, state_d;

	// walker state
	logic [NUM_AX-1:0][POS_W-1:0] pos_q;
	logic [NUM_AX-1:0][1:0] step_q;
	logic [NUM_AX-1:0][DATA_W-1:0] nb_q;
	logic [NUM_AX-1:0][DATA_W-1:0] delta_q;
	logic [ID_W-1:0] id_q;
	logic [DATA_W-1:0] exit_q;
	logic outside_q;
	logic left_q;
	logic out_valid_q;

	// working registers
	item_t item_q;
	logic [AX_W-1:0] ax_q;
	mul_kind_t kind_q;
	logic signed [MUL_A_W-1:0] mul_a_q;
	logic signed [DATA_W-1:0] mul_b_q;
	logic [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0] acc_q;
	logic signed [DATA_W-1:0] fx_q;
	logic signed [MUL_A_W-1:0] sp_q;
	logic signed [MUL_A_W-1:0] lob_q;
	logic [POS_W-1:0] k_q;
	logic signed [DATA_W-1:0] best_q;
	logic [2*CELLS_W-1:0] cxy_q;
	logic [ID_W-1:0] o_id_q;
	logic [NUM_AX-1:0][POS_W-1:0] o_pos_q;
	logic [DATA_W-1:0] o_exit_q;
	logic o_left_q;

	logic signed [DATA_W-1:0] o_s, d_s, inv_s, t0_s;
	logic signed [1:0] step_c;
	logic [SIZE_W-1:0] size_c;
	logic [CELLS_W-1:0] cells_c;
	logic signed [MUL_A_W-1:0] o38, lob_nxt;
	logic div_go;
	logic [MUL_A_W-1:0] ua;
	logic [DATA_W-1:0] ub;
	logic mul_neg;
	logic [PROD_W-1:0] lo_p;
	logic [MUL_A_W-1:0] hi_p;
	logic [MAG_W-1:0] mag, shifted;
	logic signed [DATA_W-1:0] fx_c, neg_fx, nb_sel_c;
	logic [AX_W-1:0] sel;
	logic signed [POS_W+1:0] np;
	logic np_out;
	logic signed [DATA_W:0] sum_c;
	logic [DATA_W-1:0] sat_sum;
	logic [ID_W-1:0] id_c;
	logic emit_fire;

	assign o_s = $signed(item_q.origin[ax_q]);
	assign d_s = $signed(item_q.dir[ax_q]);
	assign inv_s = $signed(item_q.inv_dir[ax_q]);
	assign t0_s = $signed(item_q.t_start);
	assign step_c = (d_s > 0) ? 2'sb01 : ((d_s < 0) ? 2'sb11 : 2'sb00);
	assign size_c = cfg.size[ax_q];
	assign cells_c = cfg.cells[ax_q];
	assign o38 = MUL_A_W'(o_s);
	assign lob_nxt = lob_q + $signed(MUL_A_W'(size_c));
	assign div_go = !sp_q[MUL_A_W-1] && ((CELLS_W'(k_q) + CELLS_W'(1)) < cells_c)
		&& (lob_nxt <= sp_q);

	// magnitude multiply, truncating shift, signed saturation
	assign ua = mul_a_q[MUL_A_W-1] ? MUL_A_W'(-mul_a_q) : MUL_A_W'(mul_a_q);
	assign ub = mul_b_q[DATA_W-1] ? DATA_W'(-mul_b_q) : DATA_W'(mul_b_q);
	assign mul_neg = mul_a_q[MUL_A_W-1] ^ mul_b_q[DATA_W-1];
	assign lo_p = ua[DATA_W-1:0] * ub;
	assign hi_p = ua[MUL_A_W-1:DATA_W] * ub;
	assign mag = MAG_W'(acc_q) + (MAG_W'(prod_q) << DATA_W);
	assign shifted = mag >> FRAC_BITS;

	always_comb begin
		if (mul_neg)
			fx_c = (|shifted[MAG_W-1:DATA_W-1]) ? SAT_MIN : -$signed(shifted[DATA_W-1:0]);
		else
			fx_c = (|shifted[MAG_W-1:DATA_W-1]) ? SAT_MAX : $signed(shifted[DATA_W-1:0]);
	end

	assign neg_fx = (fx_q == $signed(SAT_MIN)) ? $signed(SAT_MAX) : -fx_q;
	assign nb_sel_c = (step_q[ax_q] == 2'b00) ? $signed(SAT_MAX) : fx_q;

	// advance: nearest boundary, ties to y or z
	always_comb begin
		if ($signed(nb_q[0]) < $signed(nb_q[1]))
			sel = ($signed(nb_q[0]) < $signed(nb_q[2])) ? AX_W'(0) : AX_W'(2);
		else
			sel = ($signed(nb_q[1]) < $signed(nb_q[2])) ? AX_W'(1) : AX_W'(2);
	end

	assign np = $signed({2'b00, pos_q[sel]}) + (POS_W+2)'($signed(step_q[sel]));
	assign np_out = (np < 0) || (np >= $signed({1'b0, cfg.cells[sel]}));
	assign sum_c = (DATA_W+1)'($signed(nb_q[sel])) + (DATA_W+1)'($signed(delta_q[sel]));
	assign sat_sum = (sum_c[DATA_W] != sum_c[DATA_W-1])
		? (sum_c[DATA_W] ? SAT_MIN : SAT_MAX) : sum_c[DATA_W-1:0];

	assign id_c = ID_W'(pos_q[0]) + ID_W'(ID_W'(pos_q[1]) * ID_W'(cfg.cells[0]))
		+ ID_W'(ID_W'(pos_q[2]) * ID_W'(cxy_q));

	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					if (q_item.op == OP_LOAD)
						state_d = ST_AXIS;
					else if (outside_q)
						state_d = ST_EMIT;
					else
						state_d = ST_ADV;
				end
			end
			ST_AXIS: state_d = ST_MLO;
			ST_MLO: state_d = ST_MHI;
			ST_MHI: state_d = ST_MFIN;
			ST_MFIN: state_d = ST_USE;
			ST_USE: begin
				unique case (kind_q)
					MK_T: state_d = ST_DIV;
					MK_B: state_d = ST_MLO;
					MK_D: state_d = (ax_q == AX_W'(NUM_AX-1)) ? ST_ID : ST_AXIS;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_DIV: state_d = div_go ? ST_DIV : ST_MLO;
			ST_ADV: state_d = np_out ? ST_EMIT : ST_ID;
			ST_ID: state_d = ST_EMIT;
			ST_EMIT: state_d = emit_fire ? ST_IDLE : ST_EMIT;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
			step_q <= '0;
			nb_q <= {NUM_AX{SAT_MAX}};
			delta_q <= '0;
			id_q <= '0;
			exit_q <= SAT_MAX;
			outside_q <= 1'b1;
			left_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_fire)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid && q_item.op == OP_STEP && outside_q)
						left_q <= 1'b1;
				end
				ST_DIV: begin
					if (!div_go) begin
						pos_q[ax_q] <= k_q;
						step_q[ax_q] <= step_c;
					end
				end
				ST_USE: begin
					if (kind_q == MK_B)
						nb_q[ax_q] <= nb_sel_c;
					else if (kind_q == MK_D) begin
						priority if (step_q[ax_q] == 2'b01)
							delta_q[ax_q] <= fx_q;
						else if (step_q[ax_q] == 2'b11)
							delta_q[ax_q] <= neg_fx;
						else
							delta_q[ax_q] <= '0;
						if (ax_q == AX_W'(NUM_AX-1)) begin
							exit_q <= best_q;
							outside_q <= 1'b0;
							left_q <= 1'b0;
						end
					end
				end
				ST_ADV: begin
					if (np_out) begin
						outside_q <= 1'b1;
						left_q <= 1'b1;
					end else begin
						pos_q[sel] <= np[POS_W-1:0];
						nb_q[sel] <= sat_sum;
						exit_q <= sat_sum;
						left_q <= 1'b0;
					end
				end
				ST_ID: id_q <= id_c;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cxy_q <= (2*CELLS_W)'(cfg.cells[0]) * (2*CELLS_W)'(cfg.cells[1]);
		unique case (state_q)
			ST_IDLE: begin
				item_q <= q_item;
				ax_q <= '0;
				best_q <= SAT_MAX;
			end
			ST_AXIS: begin
				mul_a_q <= (t0_s > 0) ? MUL_A_W'(t0_s) : '0;
				mul_b_q <= d_s;
				kind_q <= MK_T;
			end
			ST_MLO: prod_q <= lo_p;
			ST_MHI: begin
				acc_q <= prod_q;
				prod_q <= PROD_W'(hi_p);
			end
			ST_MFIN: fx_q <= fx_c;
			ST_USE: begin
				unique case (kind_q)
					MK_T: begin
						sp_q <= o38 + MUL_A_W'(fx_q);
						lob_q <= '0;
						k_q <= '0;
					end
					MK_B: begin
						if (nb_sel_c < best_q)
							best_q <= nb_sel_c;
						mul_a_q <= $signed(MUL_A_W'(size_c));
						mul_b_q <= inv_s;
						kind_q <= MK_D;
					end
					MK_D: ax_q <= ax_q + AX_W'(1);
					default: ;
				endcase
			end
			ST_DIV: begin
				if (div_go) begin
					lob_q <= lob_nxt;
					k_q <= k_q + POS_W'(1);
				end else begin
					mul_a_q <= (step_c == 2'sb01) ? (lob_nxt - o38) : (lob_q - o38);
					mul_b_q <= inv_s;
					kind_q <= MK_B;
				end
			end
			ST_EMIT: begin
				if (emit_fire) begin
					o_id_q <= id_q;
					o_pos_q <= pos_q;
					o_exit_q <= exit_q;
					o_left_q <= left_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign voxel_id = o_id_q;
	assign voxel_x = o_pos_q[0];
	assign voxel_y = o_pos_q[1];
	assign voxel_z = o_pos_q[2];
	assign t_exit = o_exit_q;
	assign left_grid = o_left_q;
endmodule
`default_nettype wire

>>> hdl/grid_voxel_ray_walker.sv
// top level: configuration registers, front queue and back sequencer
// advance transaction: queue read, step, index and emit; the index step is skipped when
//   the step leaves the grid, and only queue read and emit run when no ray is held
// load transaction: three passes per axis through the shared 38x32 multiplier
//   and the start-index search, one cell per cycle
// one item is worked at a time, a new one is taken only back in idle; up to two more wait in the queue
// reset: asynchronous, active low; walker holds voxel 0, exit max, left_grid set
`default_nettype none
module grid_voxel_ray_walker (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic cmd,
	input  wire logic [gvrw_pkg::DATA_W-1:0] origin_x,
	input  wire logic [gvrw_pkg::DATA_W-1:0] origin_y,
	input  wire logic [gvrw_pkg::DATA_W-1:0] origin_z,
	input  wire logic [gvrw_pkg::DATA_W-1:0] dir_x,
	input  wire logic [gvrw_pkg::DATA_W-1:0] dir_y,
	input  wire logic [gvrw_pkg::DATA_W-1:0] dir_z,
	input  wire logic [gvrw_pkg::DATA_W-1:0] inv_dir_x,
	input  wire logic [gvrw_pkg::DATA_W-1:0] inv_dir_y,
	input  wire logic [gvrw_pkg::DATA_W-1:0] inv_dir_z,
	input  wire logic [gvrw_pkg::DATA_W-1:0] t_start,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [gvrw_pkg::ID_W-1:0] voxel_id,
	output logic [gvrw_pkg::POS_W-1:0] voxel_x,
	output logic [gvrw_pkg::POS_W-1:0] voxel_y,
	output logic [gvrw_pkg::POS_W-1:0] voxel_z,
	output logic [gvrw_pkg::DATA_W-1:0] t_exit,
	output logic left_grid,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [gvrw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [gvrw_pkg::DATA_W-1:0] cfg_data
);
	import gvrw_pkg::*;

	logic [NUM_AX-1:0][CELLS_W-1:0] cells_q;
	logic [NUM_AX-1:0][SIZE_W-1:0] size_q;
	cfg_t cfg;
	logic q_valid;
	item_t q_item;
	logic q_pop;
	logic cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_q <= {NUM_AX{CELLS_W'(1)}};
			size_q <= {NUM_AX{SIZE_W'(65536)}};
		end else if (cfg_we) begin
			if (cfg_index == CFG_CELLS_X) cells_q[0] <= cfg_data[CELLS_W-1:0];
			if (cfg_index == CFG_CELLS_Y) cells_q[1] <= cfg_data[CELLS_W-1:0];
			if (cfg_index == CFG_CELLS_Z) cells_q[2] <= cfg_data[CELLS_W-1:0];
			if (cfg_index == CFG_SIZE_X) size_q[0] <= cfg_data[SIZE_W-1:0];
			if (cfg_index == CFG_SIZE_Y) size_q[1] <= cfg_data[SIZE_W-1:0];
			if (cfg_index == CFG_SIZE_Z) size_q[2] <= cfg_data[SIZE_W-1:0];
		end
	end

	// effective cell counts and sizes
	always_comb begin
		for (int i = 0; i < NUM_AX; i++) begin
			if (cells_q[i] == '0)
				cfg.cells[i] = CELLS_W'(1);
			else if (cells_q[i] > CELLS_W'(MAX_CELLS))
				cfg.cells[i] = CELLS_W'(MAX_CELLS);
			else
				cfg.cells[i] = cells_q[i];
			cfg.size[i] = (size_q[i] == '0) ? SIZE_W'(1) : size_q[i];
		end
	end

	gvrw_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.origin_x(origin_x),
		.origin_y(origin_y),
		.origin_z(origin_z),
		.dir_x(dir_x),
		.dir_y(dir_y),
		.dir_z(dir_z),
		.inv_dir_x(inv_dir_x),
		.inv_dir_y(inv_dir_y),
		.inv_dir_z(inv_dir_z),
		.t_start(t_start),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop)
	);

	gvrw_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.voxel_id(voxel_id),
		.voxel_x(voxel_x),
		.voxel_y(voxel_y),
		.voxel_z(voxel_z),
		.t_exit(t_exit),
		.left_grid(left_grid)
	);
endmodule
`default_nettype wire

>>> hdl/gvrw_checker.sv
// port-level checks for the grid voxel ray walker, bound to the top level
`default_nettype none
module gvrw_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic cfg_ready,
	input wire logic [gvrw_pkg::ID_W-1:0] voxel_id,
	input wire logic [gvrw_pkg::POS_W-1:0] voxel_x,
	input wire logic [gvrw_pkg::POS_W-1:0] voxel_y,
	input wire logic [gvrw_pkg::POS_W-1:0] voxel_z,
	input wire logic [gvrw_pkg::DATA_W-1:0] t_exit,
	input wire logic left_grid
);
	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid
		&& $stable({voxel_id, voxel_x, voxel_y, voxel_z, t_exit, left_grid}))
		else $error("result changed while stalled");

	// queue only fills after an input transaction
	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && !in_stall))
		else $error("input stall rose without a transaction");

	// no result right after reset
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid)
		else $error("result valid right after reset");

	// configuration port never back-pressures
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");
endmodule

bind grid_voxel_ray_walker gvrw_checker u_gvrw_checker (.*);
`default_nettype wire

>>> test/grid_voxel_ray_walker_test.sv
// self-checking testbench for the grid voxel ray walker: loads and advances with random pacing
`timescale 1ns / 100ps
`default_nettype none
module grid_voxel_ray_walker_test;
	import gvrw_pkg::*;

	typedef struct {
		logic [ID_W-1:0] id;
		logic [POS_W-1:0] vx, vy, vz;
		logic [DATA_W-1:0] texit;
		logic left;
	} voxel_res_t;

	localparam longint TMAX = 64'sd2147483647;
	localparam longint TMIN = -64'sd2147483648;
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	item_t drv = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [ID_W-1:0] voxel_id;
	logic [POS_W-1:0] voxel_x, voxel_y, voxel_z;
	logic [DATA_W-1:0] t_exit;
	logic left_grid;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0] cfg_data = '0;

	item_t pending_rays[$];
	voxel_res_t expected_voxels[$];
	int errors = 0;
	int n_loads = 0, n_steps = 0, n_left = 0, n_checked = 0, n_cfg = 0;
	int in_gap = 0, out_gap = 0, idle_cycles = 0;
	logic quiet = 1'b0;

	// walker copy
	longint grid_cells[3], grid_size[3];
	longint wpos[3], wstep[3], wbound[3], wdelta[3], wexit;
	logic [ID_W-1:0] wid;
	logic woutside;

	always #1 clk = ~clk;

	grid_voxel_ray_walker DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(drv.op),
		.origin_x(drv.origin[0]), .origin_y(drv.origin[1]), .origin_z(drv.origin[2]),
		.dir_x(drv.dir[0]), .dir_y(drv.dir[1]), .dir_z(drv.dir[2]),
		.inv_dir_x(drv.inv_dir[0]), .inv_dir_y(drv.inv_dir[1]), .inv_dir_z(drv.inv_dir[2]),
		.t_start(drv.t_start),
		.out_valid(out_valid), .out_stall(out_stall),
		.voxel_id(voxel_id), .voxel_x(voxel_x), .voxel_y(voxel_y), .voxel_z(voxel_z),
		.t_exit(t_exit), .left_grid(left_grid),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	function automatic longint sat_t(longint v);
		if (v > TMAX) return TMAX;
		if (v < TMIN) return TMIN;
		return v;
	endfunction

	function automatic longint fix_mul(longint a, longint b);
		logic neg;
		logic [95:0] ua, ub, p;
		neg = (a < 0) != (b < 0);
		ua = 96'(a < 0 ? -a : a);
		ub = 96'(b < 0 ? -b : b);
		p = (ua * ub) >> FRAC_BITS;
		if (neg) begin
			if (p >= 96'h8000_0000) return TMIN;
			return -longint'(p);
		end
		if (p > 96'h7FFF_FFFF) return TMAX;
		return longint'(p);
	endfunction

	function automatic longint used_cells(longint c);
		if (c == 0) return 1;
		if (c > MAX_CELLS) return MAX_CELLS;
		return c;
	endfunction

	function automatic logic [ID_W-1:0] walker_id();
		longint cx, cy;
		cx = used_cells(grid_cells[0]);
		cy = used_cells(grid_cells[1]);
		return ID_W'(wpos[0] + wpos[1] * cx + wpos[2] * cx * cy);
	endfunction

	function automatic voxel_res_t walker_result(logic left);
		voxel_res_t r;
		r.id = wid;
		r.vx = POS_W'(wpos[0]);
		r.vy = POS_W'(wpos[1]);
		r.vz = POS_W'(wpos[2]);
		r.texit = DATA_W'(wexit);
		r.left = left;
		return r;
	endfunction

	task automatic walk_item(item_t it);
		longint c, s, o, d, inv, t0, sp, idx, best;
		voxel_res_t r;
		int a;
		if (it.op == OP_LOAD) begin
			n_loads++;
			t0 = longint'($signed(it.t_start));
			best = TMAX;
			for (a = 0; a < 3; a++) begin
				c = used_cells(grid_cells[a]);
				s = grid_size[a] == 0 ? 1 : grid_size[a];
				o = longint'($signed(it.origin[a]));
				d = longint'($signed(it.dir[a]));
				inv = longint'($signed(it.inv_dir[a]));
				sp = o;
				if (t0 > 0) sp = o + fix_mul(t0, d);
				idx = sp < 0 ? 0 : sp / s;
				if (idx > c - 1) idx = c - 1;
				wpos[a] = idx;
				wstep[a] = d > 0 ? 1 : (d < 0 ? -1 : 0);
				if (wstep[a] == 1) wbound[a] = fix_mul(idx * s + s - o, inv);
				else if (wstep[a] == -1) wbound[a] = fix_mul(idx * s - o, inv);
				else wbound[a] = TMAX;
				wdelta[a] = sat_t(fix_mul(s, inv) * wstep[a]);
				if (wbound[a] < best) best = wbound[a];
			end
			wexit = best;
			woutside = 1'b0;
			wid = walker_id();
			r = walker_result(1'b0);
		end else begin
			n_steps++;
			if (woutside) begin
				r = walker_result(1'b1);
			end else begin
				if (wbound[0] < wbound[1]) a = wbound[0] < wbound[2] ? 0 : 2;
				else a = wbound[1] < wbound[2] ? 1 : 2;
				idx = wpos[a] + wstep[a];
				if (idx < 0 || idx >= used_cells(grid_cells[a])) begin
					woutside = 1'b1;
					r = walker_result(1'b1);
				end else begin
					wpos[a] = idx;
					wbound[a] = sat_t(wbound[a] + wdelta[a]);
					wexit = wbound[a];
					wid = walker_id();
					r = walker_result(1'b0);
				end
			end
		end
		if (r.left) n_left++;
		expected_voxels = {expected_voxels, r};
	endtask

	task automatic report(string what, longint got, longint want);
		errors++;
		$display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want, n_checked);
	endtask

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) walk_item(drv);
			if (!(in_valid && in_stall)) begin
				if (in_gap > 0) in_gap--;
				else if (!quiet && $urandom_range(0, 15) == 0) in_gap = $urandom_range(1, 13);
				if (in_gap == 0 && pending_rays.size() > 0) begin
					drv <= pending_rays.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		voxel_res_t w;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_voxels.size() == 0) begin
					report("unexpected transaction", voxel_id, 0);
				end else begin
					w = expected_voxels.pop_front();
					if (voxel_id !== w.id) report("voxel_id", voxel_id, w.id);
					if (voxel_x !== w.vx) report("voxel_x", voxel_x, w.vx);
					if (voxel_y !== w.vy) report("voxel_y", voxel_y, w.vy);
					if (voxel_z !== w.vz) report("voxel_z", voxel_z, w.vz);
					if (t_exit !== w.texit) report("t_exit", t_exit, w.texit);
					if (left_grid !== w.left) report("left_grid", left_grid, w.left);
				end
				n_checked++;
			end
			if (out_gap > 0) out_gap--;
			else if (!quiet && $urandom_range(0, 15) == 0) out_gap = $urandom_range(1, 13);
			out_stall <= out_gap > 0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		n_cfg++;
		case (idx)
			CFG_CELLS_X: grid_cells[0] = val[CELLS_W-1:0];
			CFG_CELLS_Y: grid_cells[1] = val[CELLS_W-1:0];
			CFG_CELLS_Z: grid_cells[2] = val[CELLS_W-1:0];
			CFG_SIZE_X: grid_size[0] = val[SIZE_W-1:0];
			CFG_SIZE_Y: grid_size[1] = val[SIZE_W-1:0];
			CFG_SIZE_Z: grid_size[2] = val[SIZE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_grid(logic [DATA_W-1:0] cx, logic [DATA_W-1:0] cy,
			logic [DATA_W-1:0] cz, logic [DATA_W-1:0] sx, logic [DATA_W-1:0] sy,
			logic [DATA_W-1:0] sz);
		write_reg(CFG_CELLS_X, cx);
		write_reg(CFG_CELLS_Y, cy);
		write_reg(CFG_CELLS_Z, cz);
		write_reg(CFG_SIZE_X, sx);
		write_reg(CFG_SIZE_Y, sy);
		write_reg(CFG_SIZE_Z, sz);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain;
		while (pending_rays.size() > 0 || in_valid || expected_voxels.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic push_step(int n);
		item_t it;
		repeat (n) begin
			it = item_t'($bits(item_t)'({$urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
			it.op = OP_STEP;
			pending_rays = {pending_rays, it};
		end
	endtask

	function automatic logic [DATA_W-1:0] recip(longint d);
		if (d == 0) return SAT_MAX;
		return DATA_W'(sat_t((64'sd1 << 32) / d));
	endfunction

	function automatic item_t random_ray();
		item_t it;
		longint lim, d;
		int a;
		it.op = OP_LOAD;
		for (a = 0; a < 3; a++) begin
			lim = used_cells(grid_cells[a]) * (grid_size[a] == 0 ? 1 : grid_size[a]);
			if (lim > TMAX) lim = TMAX;
			case ($urandom_range(0, 9))
				0: it.origin[a] = $urandom;
				1: it.origin[a] = DATA_W'(-longint'($urandom_range(1, 1 << 20)));
				default: it.origin[a] = DATA_W'(longint'($urandom) % lim);
			endcase
			case ($urandom_range(0, 9))
				0: d = 0;
				1: d = longint'($signed($urandom));
				default: d = longint'($urandom_range(1, 1 << 18));
			endcase
			if ($urandom_range(0, 1)) d = -d;
			it.dir[a] = DATA_W'(d);
			it.inv_dir[a] = $urandom_range(0, 19) == 0 ? $urandom : recip(d);
		end
		case ($urandom_range(0, 3))
			0: it.t_start = $urandom;
			1: it.t_start = $urandom_range(0, 1 << 18);
			default: it.t_start = '0;
		endcase
		return it;
	endfunction

	task automatic random_phase(int n);
		item_t it;
		while (n > 0) begin
			if ($urandom_range(0, 9) == 0) begin
				it = item_t'($bits(item_t)'({$urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
				pending_rays = {pending_rays, it};
				n--;
			end else begin
				pending_rays = {pending_rays, random_ray()};
				it.op = OP_STEP;
				push_step($urandom_range(1, 30));
				n -= 8;
			end
		end
	endtask

	function automatic logic [DATA_W-1:0] pick_size();
		case ($urandom_range(0, 7))
			0: return 1;
			1: return 32'h7FFF_FFFF;
			2: return 0;
			3: return $urandom_range(1, 4096);
			4: return $urandom;
			default: return 32'(65536 * $urandom_range(1, 8));
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_cells();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return $urandom_range(17, 31);
			2: return 16;
			3: return 1;
			default: return $urandom_range(1, 16);
		endcase
	endfunction

	initial begin
		item_t it;
		int ph;
		for (ph = 0; ph < 3; ph++) begin
			grid_cells[ph] = 1;
			grid_size[ph] = 65536;
			wpos[ph] = 0;
			wstep[ph] = 0;
			wbound[ph] = TMAX;
			wdelta[ph] = 0;
		end
		wexit = TMAX;
		wid = '0;
		woutside = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// advance before any ray, then a zero-direction ray in the default grid
		push_step(2);
		it = '0;
		it.op = OP_LOAD;
		pending_rays = {pending_rays, it};
		push_step(2);
		drain();

		set_grid(4, 4, 4, 32'h10000, 32'h10000, 32'h10000);
		// diagonal ray with tie on all axes, then run off the grid
		it = '0;
		it.op = OP_LOAD;
		it.origin = {32'h8000, 32'h8000, 32'h8000};
		it.dir = {32'h10000, 32'h10000, 32'h10000};
		it.inv_dir = {32'h10000, 32'h10000, 32'h10000};
		pending_rays = {pending_rays, it};
		push_step(12);
		// negative directions, positive t_start, mismatched inverse sign
		it.dir = {32'hFFFF_0000, 32'hFFFF_8000, 32'h0002_0000};
		it.inv_dir = {32'h0001_0000, 32'hFFFE_0000, 32'h0000_8000};
		it.t_start = 32'h0001_0000;
		it.origin = {32'h0003_0000, 32'h0002_0000, 32'h0001_0000};
		pending_rays = {pending_rays, it};
		push_step(4);
		// extreme fields
		it.origin = {32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
		it.dir = {32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001};
		it.inv_dir = {32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
		it.t_start = 32'h7FFF_FFFF;
		pending_rays = {pending_rays, it};
		push_step(2);
		it.t_start = 32'h8000_0000;
		pending_rays = {pending_rays, it};
		push_step(1);
		drain();

		// out-of-range counts, zero and full sizes; steps continue the held ray
		set_grid(0, 31, 17, 0, 32'h7FFF_FFFF, 1);
		push_step(3);
		pending_rays = {pending_rays, random_ray()};
		push_step(3);
		drain();

		for (ph = 0; ph < 12; ph++) begin
			if (ph == 0) set_grid(16, 16, 16, 32'h10000, 32'h10000, 32'h10000);
			else if (ph == 1) set_grid(1, 1, 1, 1, 1, 1);
			else set_grid(pick_cells(), pick_cells(), pick_cells(),
				pick_size(), pick_size(), pick_size());
			if (ph == 11) quiet = 1'b1;
			random_phase(75);
			drain();
		end

		$display("covered %0d ray loads, %0d advances (%0d off the grid), %0d register writes",
			n_loads, n_steps, n_left, n_cfg);
		$display("checked %0d results with random pacing on both channels", n_checked);
		if (errors == 0 && expected_voxels.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
`default_nettype wire
